>>> sv/mwuf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwuf_pkg: shared types and constants of the maze wall union-find block
// Grid limits, word layouts, status codes and the cell store entry format.
// ----------------------------------------------------------------------------
package mwuf_pkg;

  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;
  localparam int NCELLS   = MAX_ROWS * MAX_COLS;
  localparam int CELL_W   = $clog2(NCELLS);

  localparam int ROW_W    = 5;
  localparam int COL_W    = 5;
  localparam int DIM_W    = 6;
  localparam int RANK_W   = 4;
  localparam int LEFT_W   = 10;
  localparam int CFG_IDX_W = 1;
  localparam int EROW_W   = $clog2(MAX_ROWS + 1);
  localparam int ECOL_W   = $clog2(MAX_COLS + 1);
  localparam int PROD_W   = EROW_W + ECOL_W;

  localparam logic [DIM_W-1:0]  DIM_RESET = DIM_W'(10);
  localparam logic [RANK_W-1:0] RANK_MAX  = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = CFG_IDX_W'(1);

  // operations and wall orientation
  localparam logic OP_BREAK  = 1'b0;
  localparam logic OP_READ   = 1'b1;
  localparam logic OR_RIGHT  = 1'b0;
  localparam logic OR_BELOW  = 1'b1;

  // result status
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_OPEN   = 2'd1;
  localparam logic [1:0] ST_JOINED = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  typedef logic [CELL_W-1:0] cell_t;

  typedef struct packed {
    logic             operation;
    logic             orientation;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              below_wall;
    logic              right_wall;
    logic [LEFT_W-1:0] walls_left;
    logic              complete;
  } out_word_t;

  typedef struct packed {
    cell_t             parent;
    logic [RANK_W-1:0] rank;
    logic              below_wall;
    logic              right_wall;
  } cell_entry_t;

  typedef struct packed {
    logic        re;
    logic        we;
    cell_t       addr;
    cell_entry_t wdata;
  } mem_req_t;

  function automatic cell_t cell_addr(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    cell_addr = CELL_W'(32'(row) * MAX_COLS + 32'(col));
  endfunction

endpackage

>>> sv/mwuf_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwuf_store: single-port cell store
// One entry per cell holding parent, rank and both wall bits; registered read.
// ----------------------------------------------------------------------------
module mwuf_store (
  input  logic                 clk_i,
  input  mwuf_pkg::mem_req_t   req_i,
  output mwuf_pkg::cell_entry_t rdata_o
);

  mwuf_pkg::cell_entry_t mem [mwuf_pkg::NCELLS];
  mwuf_pkg::cell_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/mwuf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwuf_ctrl: union-find sequencer
// Clears the store after reset, then runs reads, root finds with path
// compression, rank union and the wall update against the cell store.
// ----------------------------------------------------------------------------
module mwuf_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [mwuf_pkg::EROW_W-1:0]    rows_i,
  input  logic [mwuf_pkg::ECOL_W-1:0]    cols_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mwuf_pkg::in_word_t             in_data_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output mwuf_pkg::out_word_t            res_data_o,
  output mwuf_pkg::mem_req_t             req_o,
  input  mwuf_pkg::cell_entry_t          rdata_i
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_R_CHK = 4'd2;
  localparam logic [3:0] S_W_CHK = 4'd3;
  localparam logic [3:0] S_F_CHK = 4'd4;
  localparam logic [3:0] S_C_RD  = 4'd5;
  localparam logic [3:0] S_C_CHK = 4'd6;
  localparam logic [3:0] S_P_END = 4'd7;
  localparam logic [3:0] S_U_INC = 4'd8;
  localparam logic [3:0] S_WL_RD = 4'd9;
  localparam logic [3:0] S_WL_WR = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state_q, state_d;
  mwuf_pkg::cell_t clr_q, clr_d;
  mwuf_pkg::cell_t broken_q, broken_d;

  logic orient_q, orient_d;
  mwuf_pkg::cell_t a_q, a_d, b_q, b_d;
  mwuf_pkg::cell_t r_q, r_d, x_q, x_d, ra_q, ra_d;
  logic phase_q, phase_d;
  mwuf_pkg::cell_entry_t ra_ent_q, ra_ent_d, rb_ent_q, rb_ent_d;
  logic [1:0] status_q, status_d;
  logic bw_q, bw_d, rw_q, rw_d;

  logic find_step;
  logic out_of_range;
  mwuf_pkg::cell_t in_a;
  mwuf_pkg::cell_entry_t ent;

  logic [mwuf_pkg::PROD_W-1:0] total;
  logic [mwuf_pkg::PROD_W-1:0] left;

  // range and border checks on the incoming word
  always_comb begin
    out_of_range = (32'(in_data_i.row) >= 32'(rows_i)) || (32'(in_data_i.col) >= 32'(cols_i));
    if (in_data_i.operation == mwuf_pkg::OP_BREAK) begin
      if (in_data_i.orientation == mwuf_pkg::OR_RIGHT) begin
        out_of_range = out_of_range || (32'(in_data_i.col) + 32'd1 >= 32'(cols_i));
      end else begin
        out_of_range = out_of_range || (32'(in_data_i.row) + 32'd1 >= 32'(rows_i));
      end
    end
    in_a = mwuf_pkg::cell_addr(in_data_i.row, in_data_i.col);
  end

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    broken_d = broken_q;
    orient_d = orient_q;
    a_d      = a_q;
    b_d      = b_q;
    r_d      = r_q;
    x_d      = x_q;
    ra_d     = ra_q;
    phase_d  = phase_q;
    ra_ent_d = ra_ent_q;
    rb_ent_d = rb_ent_q;
    status_d = status_q;
    bw_d     = bw_q;
    rw_d     = rw_q;
    req_o    = '0;
    find_step = 1'b0;
    ent      = rdata_i;

    case (state_q)
      S_CLR: begin
        req_o.we                = 1'b1;
        req_o.addr              = clr_q;
        req_o.wdata.parent      = clr_q;
        req_o.wdata.rank        = '0;
        req_o.wdata.below_wall  = 1'b1;
        req_o.wdata.right_wall  = 1'b1;
        clr_d = clr_q + mwuf_pkg::CELL_W'(1);
        if (clr_q == mwuf_pkg::CELL_W'(mwuf_pkg::NCELLS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          orient_d = in_data_i.orientation;
          a_d      = in_a;
          b_d      = (in_data_i.orientation == mwuf_pkg::OR_BELOW) ?
                     in_a + mwuf_pkg::CELL_W'(mwuf_pkg::MAX_COLS) :
                     in_a + mwuf_pkg::CELL_W'(1);
          r_d      = in_a;
          x_d      = in_a;
          phase_d  = 1'b0;
          bw_d     = 1'b0;
          rw_d     = 1'b0;
          if (out_of_range) begin
            status_d = mwuf_pkg::ST_RANGE;
            state_d  = S_DONE;
          end else begin
            status_d   = mwuf_pkg::ST_DONE;
            req_o.re   = 1'b1;
            req_o.addr = in_a;
            state_d    = (in_data_i.operation == mwuf_pkg::OP_READ) ? S_R_CHK : S_W_CHK;
          end
        end
      end
      S_R_CHK: begin
        bw_d    = rdata_i.below_wall;
        rw_d    = rdata_i.right_wall;
        state_d = S_DONE;
      end
      S_W_CHK: begin
        if (((orient_q == mwuf_pkg::OR_BELOW) ? rdata_i.below_wall : rdata_i.right_wall)
            == 1'b0) begin
          status_d = mwuf_pkg::ST_OPEN;
          state_d  = S_DONE;
        end else begin
          find_step = 1'b1;
        end
      end
      S_F_CHK: begin
        find_step = 1'b1;
      end
      S_C_RD: begin
        req_o.re   = 1'b1;
        req_o.addr = x_q;
        state_d    = S_C_CHK;
      end
      S_C_CHK: begin
        ent.parent  = r_q;
        req_o.we    = 1'b1;
        req_o.addr  = x_q;
        req_o.wdata = ent;
        x_d = rdata_i.parent;
        state_d = (rdata_i.parent == r_q) ? S_P_END : S_C_RD;
      end
      S_P_END: begin
        if (!phase_q) begin
          ra_d       = r_q;
          phase_d    = 1'b1;
          r_d        = b_q;
          x_d        = b_q;
          req_o.re   = 1'b1;
          req_o.addr = b_q;
          state_d    = S_F_CHK;
        end else if (ra_q == r_q) begin
          status_d = mwuf_pkg::ST_JOINED;
          state_d  = S_DONE;
        end else if (ra_ent_q.rank > rb_ent_q.rank) begin
          ent         = rb_ent_q;
          ent.parent  = ra_q;
          req_o.we    = 1'b1;
          req_o.addr  = r_q;
          req_o.wdata = ent;
          state_d     = S_WL_RD;
        end else begin
          ent         = ra_ent_q;
          ent.parent  = r_q;
          req_o.we    = 1'b1;
          req_o.addr  = ra_q;
          req_o.wdata = ent;
          state_d     = (ra_ent_q.rank == rb_ent_q.rank) ? S_U_INC : S_WL_RD;
        end
      end
      S_U_INC: begin
        ent      = rb_ent_q;
        ent.rank = (rb_ent_q.rank == mwuf_pkg::RANK_MAX) ? mwuf_pkg::RANK_MAX :
                   rb_ent_q.rank + mwuf_pkg::RANK_W'(1);
        req_o.we    = 1'b1;
        req_o.addr  = r_q;
        req_o.wdata = ent;
        state_d     = S_WL_RD;
      end
      S_WL_RD: begin
        req_o.re   = 1'b1;
        req_o.addr = a_q;
        state_d    = S_WL_WR;
      end
      S_WL_WR: begin
        if (orient_q == mwuf_pkg::OR_BELOW) begin
          ent.below_wall = 1'b0;
        end else begin
          ent.right_wall = 1'b0;
        end
        req_o.we    = 1'b1;
        req_o.addr  = a_q;
        req_o.wdata = ent;
        broken_d    = broken_q + mwuf_pkg::CELL_W'(1);
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // one step of the root walk, then the compression walk from the start cell
    if (find_step) begin
      if (rdata_i.parent == r_q) begin
        if (!phase_q) begin
          ra_ent_d = rdata_i;
        end else begin
          rb_ent_d = rdata_i;
        end
        if (x_q != r_q) begin
          req_o.re   = 1'b1;
          req_o.addr = x_q;
          state_d    = S_C_CHK;
        end else begin
          state_d = S_P_END;
        end
      end else begin
        r_d        = rdata_i.parent;
        req_o.re   = 1'b1;
        req_o.addr = rdata_i.parent;
        state_d    = S_F_CHK;
      end
    end
  end

  // walls left after this word
  always_comb begin
    total = mwuf_pkg::PROD_W'(rows_i) * mwuf_pkg::PROD_W'(cols_i) - mwuf_pkg::PROD_W'(1);
    left  = (mwuf_pkg::PROD_W'(broken_q) >= total) ? '0 : total - mwuf_pkg::PROD_W'(broken_q);
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_data_o.status     = status_q;
    res_data_o.below_wall = bw_q;
    res_data_o.right_wall = rw_q;
    res_data_o.walls_left = mwuf_pkg::LEFT_W'(left);
    res_data_o.complete   = (left == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      broken_q <= '0;
      phase_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      broken_q <= broken_d;
      phase_q  <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    orient_q <= orient_d;
    a_q      <= a_d;
    b_q      <= b_d;
    r_q      <= r_d;
    x_q      <= x_d;
    ra_q     <= ra_d;
    ra_ent_q <= ra_ent_d;
    rb_ent_q <= rb_ent_d;
    status_q <= status_d;
    bw_q     <= bw_d;
    rw_q     <= rw_d;
  end

endmodule

>>> sv/maze_wall_union_find.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_wall_union_find: Kruskal maze builder over a union-find cell store
// Input words propose breaking a wall or read a cell's walls; every input
// word gives exactly one output word. Both channels use valid/ready and a
// word moves when both are high. The config port writes grid_rows (index 0)
// or grid_cols (index 1) on any edge with cfg_we_i high; write only when idle.
// After reset the block sweeps all 1024 cell store entries (one entry a
// cycle) with in_ready_o low, then accepts words one at a time.
// An out-of-range word needs no store access; a read or an already open
// wall needs one store read. A full proposal walks each side to its root,
// compresses each non-empty walk, links the roots by rank (raising the rank
// on a tie) and clears the wall; a joined pair skips the link and the wall.
// Union by rank keeps each root walk at ten parent hops or below. The
// single-port store serialises every access. The next word is accepted
// the cycle after a result is registered. A result waiting on a stalled
// receiver sits in the output register while the next word is accepted
// and worked on; that one then waits for the slot.
// ----------------------------------------------------------------------------
module maze_wall_union_find (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  mwuf_pkg::in_word_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output mwuf_pkg::out_word_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [mwuf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mwuf_pkg::DIM_W-1:0]        cfg_data_i
);

  logic [mwuf_pkg::DIM_W-1:0]  rows_cfg_q, cols_cfg_q;
  logic [mwuf_pkg::EROW_W-1:0] rows_eff;
  logic [mwuf_pkg::ECOL_W-1:0] cols_eff;

  logic                  out_valid_q;
  mwuf_pkg::out_word_t   out_data_q;
  logic                  res_valid, res_ready;
  mwuf_pkg::out_word_t   res_data;
  mwuf_pkg::mem_req_t    req;
  mwuf_pkg::cell_entry_t rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= mwuf_pkg::DIM_RESET;
      cols_cfg_q <= mwuf_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mwuf_pkg::CFG_ROWS: rows_cfg_q <= cfg_data_i;
        mwuf_pkg::CFG_COLS: cols_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero counts as one, large values clamp to the grid maximum
  always_comb begin
    if (rows_cfg_q == '0) begin
      rows_eff = mwuf_pkg::EROW_W'(1);
    end else if (32'(rows_cfg_q) > mwuf_pkg::MAX_ROWS) begin
      rows_eff = mwuf_pkg::EROW_W'(mwuf_pkg::MAX_ROWS);
    end else begin
      rows_eff = mwuf_pkg::EROW_W'(rows_cfg_q);
    end
    if (cols_cfg_q == '0) begin
      cols_eff = mwuf_pkg::ECOL_W'(1);
    end else if (32'(cols_cfg_q) > mwuf_pkg::MAX_COLS) begin
      cols_eff = mwuf_pkg::ECOL_W'(mwuf_pkg::MAX_COLS);
    end else begin
      cols_eff = mwuf_pkg::ECOL_W'(cols_cfg_q);
    end
  end

  mwuf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rows_i      (rows_eff),
    .cols_i      (cols_eff),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data),
    .req_o       (req),
    .rdata_i     (rdata)
  );

  mwuf_store u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> sv/mwuf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwuf_checker: port-level checks of the maze wall union-find block
// Watches the top-level ports only; attached by a bind statement.
// ----------------------------------------------------------------------------
module mwuf_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input mwuf_pkg::out_word_t               out_data_o
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed under stall");

  // complete flag tracks the wall count
  a_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.complete == (out_data_o.walls_left == '0)))
    else $error("complete disagrees with walls_left");

  // wall bits only come back on a successful read
  a_walls_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != mwuf_pkg::ST_DONE) |->
      !out_data_o.below_wall && !out_data_o.right_wall)
    else $error("wall bits set on a non-read result");

  // store sweep keeps the input closed straight after reset
  a_clear_closed: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("input open during store sweep");

endmodule

bind maze_wall_union_find mwuf_checker u_checker (.*);

>>> dv/tb_maze_wall_union_find.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_maze_wall_union_find: self-checking bench for the maze wall union-find
// A shadow copy of the cell store (parents, ranks, wall bits, broken count)
// predicts every output word from the input words accepted. Directed words
// cover border walls, open walls, joined cells and out-of-grid cells; random
// phases then run mostly legal wall proposals under several grid sizes,
// including the register extremes, with random idling on both channels.
// ----------------------------------------------------------------------------
import mwuf_pkg::*;

class maze_shadow;
  logic [DIM_W-1:0]  rows_reg;
  logic [DIM_W-1:0]  cols_reg;
  cell_t             parent [NCELLS];
  logic [RANK_W-1:0] rank [NCELLS];
  logic              below_up [NCELLS];
  logic              right_up [NCELLS];
  int unsigned       broken;
  out_word_t         expected_q [$];
  int unsigned       mismatches;

  function new();
    rows_reg = DIM_RESET;
    cols_reg = DIM_RESET;
    for (int i = 0; i < NCELLS; i++) begin
      parent[i]   = cell_t'(i);
      rank[i]     = '0;
      below_up[i] = 1'b1;
      right_up[i] = 1'b1;
    end
    broken     = 0;
    mismatches = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    if (idx == CFG_ROWS) rows_reg = val;
    else if (idx == CFG_COLS) cols_reg = val;
  endfunction

  function int unsigned dim_of(logic [DIM_W-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // root walk with full path compression
  function cell_t root_of(cell_t x);
    cell_t r;
    cell_t nxt;
    r = x;
    while (parent[r] != r) r = parent[r];
    while (x != r) begin
      nxt       = parent[x];
      parent[x] = r;
      x         = nxt;
    end
    return r;
  endfunction

  function void note_word(in_word_t w);
    int unsigned n_rows;
    int unsigned n_cols;
    int unsigned total;
    int unsigned left;
    cell_t       a;
    cell_t       b;
    cell_t       ra;
    cell_t       rb;
    logic        standing;
    out_word_t   e;
    n_rows   = dim_of(rows_reg, MAX_ROWS);
    n_cols   = dim_of(cols_reg, MAX_COLS);
    e        = '0;
    e.status = ST_DONE;
    a        = cell_t'(int'(w.row) * MAX_COLS + int'(w.col));
    if (w.row >= n_rows || w.col >= n_cols) begin
      e.status = ST_RANGE;
    end else if (w.operation == OP_READ) begin
      e.below_wall = below_up[a];
      e.right_wall = right_up[a];
    end else if ((w.orientation == OR_RIGHT && int'(w.col) + 1 >= n_cols) ||
                 (w.orientation == OR_BELOW && int'(w.row) + 1 >= n_rows)) begin
      e.status = ST_RANGE;
    end else begin
      b        = (w.orientation == OR_BELOW) ? cell_t'(a + MAX_COLS) : cell_t'(a + 1);
      standing = (w.orientation == OR_BELOW) ? below_up[a] : right_up[a];
      if (!standing) begin
        e.status = ST_OPEN;
      end else begin
        ra = root_of(a);
        rb = root_of(b);
        if (ra == rb) begin
          e.status = ST_JOINED;
        end else begin
          if (w.orientation == OR_BELOW) below_up[a] = 1'b0;
          else right_up[a] = 1'b0;
          broken++;
          if (rank[ra] > rank[rb]) begin
            parent[rb] = ra;
          end else begin
            if (rank[ra] == rank[rb] && rank[rb] != RANK_MAX) rank[rb]++;
            parent[ra] = rb;
          end
        end
      end
    end
    total        = n_rows * n_cols - 1;
    left         = (broken >= total) ? 0 : total - broken;
    e.walls_left = LEFT_W'(left);
    e.complete   = (left == 0);
    expected_q.push_back(e);
  endfunction

  function void check_word(out_word_t got);
    out_word_t e;
    bit        bad;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: output word with none expected: %p", $realtime, got);
      return;
    end
    e   = expected_q.pop_front();
    bad = (got.status !== e.status) || (got.below_wall !== e.below_wall) ||
          (got.right_wall !== e.right_wall) || (got.walls_left !== e.walls_left) ||
          (got.complete !== e.complete);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"%0t: mismatch status %0d/%0d below %0d/%0d right %0d/%0d",
                  " left %0d/%0d done %0d/%0d (exp/got)"},
                 $realtime, e.status, got.status, e.below_wall, got.below_wall,
                 e.right_wall, got.right_wall, e.walls_left, got.walls_left,
                 e.complete, got.complete);
    end
  endfunction
endclass

module tb_maze_wall_union_find;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_word_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DIM_W-1:0]     cfg_data;

  maze_shadow shadow;
  bit         quiet;

  // grid settings per random phase
  logic [DIM_W-1:0] phase_rows  [7] = '{6'd1, 6'd0, 6'd63, 6'd32, 6'd0, 6'd45, 6'd5};
  logic [DIM_W-1:0] phase_cols  [7] = '{6'd1, 6'd63, 6'd0, 6'd32, 6'd0, 6'd33, 6'd7};
  int unsigned      phase_words [7] = '{40, 150, 150, 600, 30, 200, 100};
  bit               phase_quiet [7] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

  maze_wall_union_find i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) shadow.note_word(in_data);
      if (out_valid && out_ready) shadow.check_word(out_data);
    end
  end

  // receiver with random stalls
  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic in_word_t wall_word(logic op, logic orient, int row, int col);
    in_word_t w;
    w.operation   = op;
    w.orientation = orient;
    w.row         = ROW_W'(row);
    w.col         = COL_W'(col);
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned pick;
    int unsigned nr;
    int unsigned nc;
    nr   = shadow.dim_of(shadow.rows_reg, MAX_ROWS);
    nc   = shadow.dim_of(shadow.cols_reg, MAX_COLS);
    w    = in_word_t'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      w.operation = OP_BREAK;
      if (nc > 1 && (nr == 1 || $urandom_range(0, 1) == 0)) begin
        w.orientation = OR_RIGHT;
        w.row         = ROW_W'($urandom_range(0, nr - 1));
        w.col         = COL_W'($urandom_range(0, nc - 2));
      end else if (nr > 1) begin
        w.orientation = OR_BELOW;
        w.row         = ROW_W'($urandom_range(0, nr - 2));
        w.col         = COL_W'($urandom_range(0, nc - 1));
      end
    end else if (pick < 82) begin
      w.operation = OP_READ;
      w.row       = ROW_W'($urandom_range(0, nr - 1));
      w.col       = COL_W'($urandom_range(0, nc - 1));
    end
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the sender until every expected word is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (shadow.expected_q.size() != 0);
  endtask

  task automatic set_grid(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_ROWS;
    cfg_data <= rows;
    @(posedge clk);
    shadow.write_reg(CFG_ROWS, rows);
    cfg_idx  <= CFG_COLS;
    cfg_data <= cols;
    @(posedge clk);
    shadow.write_reg(CFG_COLS, cols);
    cfg_we   <= 1'b0;
  endtask

  task automatic run_random(int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(0, 199) == 0) drain();
      send_word(random_word());
    end
  endtask

  initial begin
    shadow   = new();
    quiet    = 1'b0;
    rst_n    = 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= '0;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed words on the reset grid of 10 by 10
    send_word(wall_word(OP_READ,  OR_RIGHT, 0, 0));
    send_word(wall_word(OP_READ,  OR_BELOW, 9, 9));
    send_word(wall_word(OP_BREAK, OR_RIGHT, 0, 0));
    send_word(wall_word(OP_BREAK, OR_RIGHT, 0, 0));
    send_word(wall_word(OP_BREAK, OR_BELOW, 0, 0));
    send_word(wall_word(OP_BREAK, OR_RIGHT, 1, 0));
    send_word(wall_word(OP_BREAK, OR_BELOW, 0, 1));
    send_word(wall_word(OP_READ,  OR_RIGHT, 0, 0));
    send_word(wall_word(OP_READ,  OR_BELOW, 0, 1));
    send_word(wall_word(OP_BREAK, OR_RIGHT, 0, 9));
    send_word(wall_word(OP_BREAK, OR_BELOW, 9, 0));
    send_word(wall_word(OP_BREAK, OR_RIGHT, 9, 9));
    send_word(wall_word(OP_BREAK, OR_BELOW, 9, 9));
    send_word(wall_word(OP_READ,  OR_RIGHT, 10, 0));
    send_word(wall_word(OP_READ,  OR_BELOW, 0, 10));
    send_word(wall_word(OP_BREAK, OR_BELOW, 31, 31));
    send_word(wall_word(OP_READ,  OR_BELOW, 31, 31));
    send_word(wall_word(OP_BREAK, OR_BELOW, 8, 9));
    send_word(wall_word(OP_BREAK, OR_RIGHT, 9, 8));
    send_word(wall_word(OP_READ,  OR_RIGHT, 9, 9));
    send_word(wall_word(OP_BREAK, OR_BELOW, 8, 8));
    send_word(wall_word(OP_BREAK, OR_RIGHT, 8, 8));
    send_word(wall_word(OP_BREAK, OR_BELOW, 8, 9));
    run_random(557);

    for (int p = 0; p < 7; p++) begin
      drain();
      set_grid(phase_rows[p], phase_cols[p]);
      quiet = phase_quiet[p];
      run_random(phase_words[p]);
    end

    quiet = 1'b0;
    drain();
    repeat (100) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/mwuf_pkg.sv
sv/mwuf_store.sv
sv/mwuf_ctrl.sv
sv/maze_wall_union_find.sv
sv/mwuf_checker.sv
dv/tb_maze_wall_union_find.sv
